FILE: rtl/core/mfs_pkg.sv
// Shared types and constants of the multilevel feedback scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package mfs_pkg;

  localparam int DEF_MAX_JOBS   = 64;
  localparam int DEF_NUM_LEVELS = 12;

  localparam logic [7:0] QUANTUM_RESET = 8'd2;

  localparam logic ACT_ARRIVAL = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  localparam logic [1:0] EV_STARTED  = 2'd0;
  localparam logic [1:0] EV_RESUMED  = 2'd1;
  localparam logic [1:0] EV_STOPPED  = 2'd2;
  localparam logic [1:0] EV_FINISHED = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // take in the input item
    logic arr_write;   // write job entry, enqueue
    logic tick_read;   // read the running job
    logic tick_eval;   // charge one tick, stop or finish
    logic tick_emit;   // show the stop or finish result
    logic disp_sel;    // latch the first non-empty level
    logic rd_pop;      // pop the overflow level
    logic rd_job;      // read the popped job
    logic rd_push;     // requeue at its own priority
    logic dp_pop;      // pop the chosen level
    logic dp_job;      // read the dispatched job
    logic dp_done;     // update wait, start running, show result
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic run_valid;
    logic tk_event;
    logic any_low;
    logic over_ne;
  } status_t;

endpackage

FILE: rtl/core/multilevel_feedback_scheduler.sv
// Top level of the multilevel feedback queue scheduler.
// Joins controller and datapath; depends on mfs_pkg, mfs_ctrl, mfs_datapath.
//
// Use: raise start with an item on action and the job fields; it transfers at
// the edge where start is high and busy is low. An arrival (action 0) enters
// a job into its level; a tick (action 1) advances time and charges the
// running job. Each result is shown for one cycle with result_valid high and
// transfers at the end of that cycle; last_of_run marks the final result of an
// item. The receiver cannot stall, so results are never held.
// The quantum register is written through cfg_valid/cfg_ready/cfg_data while
// busy is low.
// Steps of an item: an arrival writes the job entry; a tick reads the running
// job and charges it, and shows a result when it stops or finishes the job.
// An arrival, and a tick that stops or finishes a job or finds none running,
// then look for a dispatch (pop, job read, done), whose result shows in the
// cycle after its done step. Refilling from the overflow level pops, reads and
// requeues each job it holds, then scans the levels again, as the queue RAM
// and the job RAM each have a single read port.
// Reset (rst, synchronous) empties all levels, frees every slot, stops the
// running job, clears the tick count and sets the quantum to 2.
module multilevel_feedback_scheduler
  import mfs_pkg::*;
#(
  parameter int MAX_JOBS   = DEF_MAX_JOBS,
  parameter int NUM_LEVELS = DEF_NUM_LEVELS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              action,
  input  logic [5:0]        job_index,
  input  logic signed [7:0] priority_level,
  input  logic [15:0]       run_length,
  input  logic [15:0]       arrival_stamp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  output logic              result_valid,
  output logic [1:0]        event_kind,
  output logic [5:0]        job_slot,
  output logic [15:0]       event_time,
  output logic [15:0]       job_arrival,
  output logic [15:0]       job_total,
  output logic [15:0]       job_remaining,
  output logic [15:0]       job_wait,
  output logic [15:0]       turnaround,
  output logic              last_of_run
);

  cmd_t    cmd;
  status_t status;

  // configuration transfers only while idle
  assign cfg_ready = !busy;

  mfs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  mfs_datapath #(.MAX_JOBS(MAX_JOBS), .NUM_LEVELS(NUM_LEVELS)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .job_index      (job_index),
    .priority_level (priority_level),
    .run_length     (run_length),
    .arrival_stamp  (arrival_stamp),
    .result_valid   (result_valid),
    .event_kind     (event_kind),
    .job_slot       (job_slot),
    .event_time     (event_time),
    .job_arrival    (job_arrival),
    .job_total      (job_total),
    .job_remaining  (job_remaining),
    .job_wait       (job_wait),
    .turnaround     (turnaround),
    .last_of_run    (last_of_run)
  );

endmodule

FILE: rtl/core/mfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/mfs_ctrl.sv
// Controller state machine of the scheduler: sequences arrivals, ticks,
// overflow redistribution and dispatch. Depends on mfs_pkg.
module mfs_ctrl
  import mfs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    action,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_ARR     = 4'd1;
  localparam logic [3:0] S_TK_READ = 4'd2;
  localparam logic [3:0] S_TK_EVAL = 4'd3;
  localparam logic [3:0] S_TK_EMIT = 4'd4;
  localparam logic [3:0] S_DISP    = 4'd5;
  localparam logic [3:0] S_RD_POP  = 4'd6;
  localparam logic [3:0] S_RD_JOB  = 4'd7;
  localparam logic [3:0] S_RD_PUSH = 4'd8;
  localparam logic [3:0] S_DP_POP  = 4'd9;
  localparam logic [3:0] S_DP_JOB  = 4'd10;
  localparam logic [3:0] S_DP_DONE = 4'd11;

  logic [3:0] state, state_next;

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = (action == ACT_TICK) ? S_TK_READ : S_ARR;
        end
      end
      S_ARR: begin
        cmd.arr_write = 1'b1;
        state_next    = S_DISP;
      end
      S_TK_READ: begin
        cmd.tick_read = 1'b1;
        state_next    = status.run_valid ? S_TK_EVAL : S_DISP;
      end
      S_TK_EVAL: begin
        cmd.tick_eval = 1'b1;
        state_next    = status.tk_event ? S_TK_EMIT : S_IDLE;
      end
      S_TK_EMIT: begin
        cmd.tick_emit = 1'b1;
        state_next    = S_DISP;
      end
      S_DISP: begin
        cmd.disp_sel = 1'b1;
        priority if (status.run_valid) begin
          state_next = S_IDLE;
        end else if (status.any_low) begin
          state_next = S_DP_POP;
        end else if (status.over_ne) begin
          state_next = S_RD_POP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RD_POP: begin
        cmd.rd_pop = 1'b1;
        state_next = S_RD_JOB;
      end
      S_RD_JOB: begin
        cmd.rd_job = 1'b1;
        state_next = S_RD_PUSH;
      end
      S_RD_PUSH: begin
        cmd.rd_push = 1'b1;
        state_next  = status.over_ne ? S_RD_POP : S_DISP;
      end
      S_DP_POP: begin
        cmd.dp_pop = 1'b1;
        state_next = S_DP_JOB;
      end
      S_DP_JOB: begin
        cmd.dp_job = 1'b1;
        state_next = S_DP_DONE;
      end
      S_DP_DONE: begin
        cmd.dp_done = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/mfs_datapath.sv
// Datapath of the scheduler: job table and level queues in RAM, queue
// pointers, running-job registers and result registers. Depends on mfs_pkg, mfs_ram.
module mfs_datapath
  import mfs_pkg::*;
#(
  parameter int MAX_JOBS   = DEF_MAX_JOBS,
  parameter int NUM_LEVELS = DEF_NUM_LEVELS
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic [5:0]         job_index,
  input  logic signed [7:0]  priority_level,
  input  logic [15:0]        run_length,
  input  logic [15:0]        arrival_stamp,
  output logic               result_valid,
  output logic [1:0]         event_kind,
  output logic [5:0]         job_slot,
  output logic [15:0]        event_time,
  output logic [15:0]        job_arrival,
  output logic [15:0]        job_total,
  output logic [15:0]        job_remaining,
  output logic [15:0]        job_wait,
  output logic [15:0]        turnaround,
  output logic               last_of_run
);

  localparam int SW     = $clog2(MAX_JOBS);
  localparam int LW     = $clog2(NUM_LEVELS);
  localparam int CW     = $clog2(MAX_JOBS + 1);
  localparam int TOP    = NUM_LEVELS - 2;
  localparam int OVER   = NUM_LEVELS - 1;
  localparam int JW     = 64 + LW;
  localparam int QDEPTH = NUM_LEVELS * (2 ** SW);

  // captured arrival
  logic [SW-1:0] a_slot;
  logic          a_ok;
  logic [LW-1:0] a_prio;
  logic [15:0]   a_run;
  logic [15:0]   a_arr;
  logic [LW-1:0] prio_clamp;

  // scheduler state
  logic [15:0]   tick_count;
  logic [7:0]    quantum;
  logic [MAX_JOBS-1:0] job_busy;
  logic          run_valid;
  logic [SW-1:0] run_job;
  logic [LW-1:0] run_lvl;
  logic [15:0]   slice_start;
  logic [SW-1:0] slot_r;
  logic [LW-1:0] found_r;

  logic [SW-1:0] q_head  [NUM_LEVELS];
  logic [SW-1:0] q_tail  [NUM_LEVELS];
  logic [CW-1:0] q_count [NUM_LEVELS];

  // RAM ports
  logic          q_we;
  logic [LW+SW-1:0] q_waddr, q_raddr;
  logic [SW-1:0] q_wdata, q_rdata;
  logic          j_we;
  logic [SW-1:0] j_waddr, j_raddr;
  logic [JW-1:0] j_wdata, j_rdata;

  // job word fields
  logic [15:0]   j_arr, j_tot, j_rem, j_wait;
  logic [LW-1:0] j_prio;
  assign j_arr  = j_rdata[15:0];
  assign j_tot  = j_rdata[31:16];
  assign j_rem  = j_rdata[47:32];
  assign j_wait = j_rdata[63:48];
  assign j_prio = j_rdata[JW-1:64];

  // tick evaluation
  logic [15:0] rem_n, q16, wait_n;
  logic        fin, stop, arr_ok;
  logic [LW-1:0] demote_lvl, lvl;
  logic        push_en, pop_en;
  logic [LW-1:0] found;
  logic        any_low;
  logic        tick_adv;

  assign rem_n  = (j_rem != 16'd0) ? j_rem - 16'd1 : 16'd0;
  assign q16    = {8'd0, (quantum == 8'd0) ? 8'd1 : quantum};
  assign fin    = (rem_n == 16'd0);
  assign stop   = !fin && ((tick_count - slice_start) == q16);
  assign wait_n = (tick_count - j_arr) - (j_tot - j_rem);
  assign arr_ok = a_ok && (a_run != 16'd0) && !job_busy[a_slot];
  assign demote_lvl = (run_lvl == LW'(OVER)) ? LW'(OVER) : run_lvl + LW'(1);

  // tick advance is taken at the first cycle of a tick item
  assign tick_adv = cmd.tick_read;

  // saturate the requested priority
  always_comb begin
    int p;
    p = int'(priority_level);
    if (p < 0) p = 0;
    if (p > TOP) p = TOP;
    prio_clamp = LW'(p);
  end

  // first non-empty level among the ordinary ones
  always_comb begin
    found   = '0;
    any_low = 1'b0;
    for (int i = TOP; i >= 0; i--) begin
      if (q_count[i] != '0) begin
        found   = LW'(i);
        any_low = 1'b1;
      end
    end
  end

  assign status.run_valid = run_valid;
  assign status.tk_event  = fin || stop;
  assign status.any_low   = any_low;
  assign status.over_ne   = (q_count[OVER] != '0);

  // level selected for this cycle's queue operation
  always_comb begin
    lvl     = found_r;
    q_wdata = slot_r;
    push_en = 1'b0;
    priority if (cmd.arr_write) begin
      lvl     = a_prio;
      q_wdata = a_slot;
      push_en = arr_ok;
    end else if (cmd.tick_eval) begin
      lvl     = demote_lvl;
      q_wdata = run_job;
      push_en = stop;
    end else if (cmd.rd_pop) begin
      lvl = LW'(OVER);
    end else if (cmd.rd_push) begin
      lvl     = j_prio;
      push_en = 1'b1;
    end else begin
      lvl = found_r;
    end
    push_en = push_en && (q_count[lvl] < CW'(MAX_JOBS));
  end

  assign pop_en  = cmd.rd_pop || cmd.dp_pop;
  assign q_we    = push_en;
  assign q_waddr = {lvl, q_tail[lvl]};
  assign q_raddr = {lvl, q_head[lvl]};

  // job table access
  always_comb begin
    j_raddr = cmd.tick_read ? run_job : q_rdata;
    j_we    = 1'b0;
    j_waddr = slot_r;
    j_wdata = {j_prio, wait_n, j_rem, j_tot, j_arr};
    priority if (cmd.arr_write) begin
      j_we    = arr_ok;
      j_waddr = a_slot;
      j_wdata = {a_prio, 16'd0, a_run, a_run, a_arr};
    end else if (cmd.tick_eval) begin
      j_we    = 1'b1;
      j_waddr = run_job;
      j_wdata = {j_prio, j_wait, rem_n, j_tot, j_arr};
    end else if (cmd.dp_done) begin
      j_we    = 1'b1;
    end else begin
      j_we    = 1'b0;
    end
  end

  mfs_ram #(.WIDTH(SW), .DEPTH(QDEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  mfs_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk   (clk),
    .we    (j_we),
    .waddr (j_waddr),
    .wdata (j_wdata),
    .raddr (j_raddr),
    .rdata (j_rdata)
  );

  // capture the input item, the popped slot and the selected level
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a_slot <= SW'(job_index);
      a_ok   <= (int'(job_index) < MAX_JOBS);
      a_prio <= prio_clamp;
      a_run  <= run_length;
      a_arr  <= arrival_stamp;
    end
    if (cmd.rd_job || cmd.dp_job) begin
      slot_r <= q_rdata;
    end
    if (cmd.disp_sel) begin
      found_r <= found;
    end
  end

  // queue pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        q_head[i]  <= '0;
        q_tail[i]  <= '0;
        q_count[i] <= '0;
      end
    end else begin
      if (push_en) begin
        q_tail[lvl]  <= (q_tail[lvl] == SW'(MAX_JOBS - 1)) ? '0 : q_tail[lvl] + SW'(1);
        q_count[lvl] <= q_count[lvl] + CW'(1);
      end
      if (pop_en) begin
        q_head[lvl]  <= (q_head[lvl] == SW'(MAX_JOBS - 1)) ? '0 : q_head[lvl] + SW'(1);
        q_count[lvl] <= q_count[lvl] - CW'(1);
      end
    end
  end

  // time, quantum, busy slots and the running job
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      quantum     <= QUANTUM_RESET;
      job_busy    <= '0;
      run_valid   <= 1'b0;
      run_job     <= '0;
      run_lvl     <= '0;
      slice_start <= '0;
    end else begin
      if (cfg_we) begin
        quantum <= cfg_data;
      end
      if (cmd.arr_write && arr_ok) begin
        job_busy[a_slot] <= 1'b1;
      end
      if (cmd.tick_eval && (fin || stop)) begin
        run_valid <= 1'b0;
        if (fin) begin
          job_busy[run_job] <= 1'b0;
        end
      end
      if (cmd.dp_done) begin
        run_valid   <= 1'b1;
        run_job     <= slot_r;
        run_lvl     <= found_r;
        slice_start <= tick_count;
      end
      if (tick_adv) begin
        tick_count <= tick_count + 16'd1;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.tick_emit || cmd.dp_done;
    end
    if (cmd.tick_eval) begin
      event_kind    <= fin ? EV_FINISHED : EV_STOPPED;
      job_slot      <= 6'(run_job);
      event_time    <= tick_count;
      job_arrival   <= j_arr;
      job_total     <= j_tot;
      job_remaining <= fin ? 16'd0 : rem_n;
      job_wait      <= j_wait;
      turnaround    <= fin ? tick_count - j_arr : 16'd0;
    end
    if (cmd.tick_emit) begin
      last_of_run <= !(any_low || status.over_ne);
    end
    if (cmd.dp_done) begin
      event_kind    <= (j_tot == j_rem) ? EV_STARTED : EV_RESUMED;
      job_slot      <= 6'(slot_r);
      event_time    <= tick_count;
      job_arrival   <= j_arr;
      job_total     <= j_tot;
      job_remaining <= j_rem;
      job_wait      <= wait_n;
      turnaround    <= 16'd0;
      last_of_run   <= 1'b1;
    end
  end

endmodule
